FILE: hdl/gpc_pkg.sv
// shared constants, register indexes and exp lookup tables for the gaussian cost core
// no dependencies; used by gpc_lane and gaussian_potential_cost_core
package gpc_pkg;

    // field widths
    localparam int COORD_W  = 12;
    localparam int CENTER_W = 24;
    localparam int PEAK_W   = 12;
    localparam int INVW_W   = 16;
    localparam int COST_W   = 16;
    localparam int CFG_W    = 24;
    localparam int ADDR_W   = 3;
    localparam int EXP_W    = 17;
    localparam int TERM_W   = PEAK_W + EXP_W;
    localparam int MAX_CENTERS = 6;
    localparam int NUM_CENTERS_DEF = 6;

    // configuration register indexes
    localparam logic [ADDR_W-1:0] CFG_CENTER_A  = 3'd0;
    localparam logic [ADDR_W-1:0] CFG_CENTER_F  = 3'd5;
    localparam logic [ADDR_W-1:0] CFG_PEAK_GAIN = 3'd6;
    localparam logic [ADDR_W-1:0] CFG_INV_WIDTH = 3'd7;

    // reset values
    localparam logic [CENTER_W-1:0] CENTER_RST [MAX_CENTERS] = '{
        24'd2097920, 24'd2098944, 24'd5243648,
        24'd5244672, 24'd8389376, 24'd8390400
    };
    localparam logic [PEAK_W-1:0] PEAK_RST = 12'd2304;
    localparam logic [INVW_W-1:0] INVW_RST = 16'd4096;

    // one in Q1.16
    localparam logic [EXP_W-1:0] ONE_Q16 = 17'h10000;

    // per-lane stage enables
    typedef struct packed {
        logic en_sq;
        logic en_scale;
        logic en_exp_a;
        logic en_exp_b;
        logic en_exp_c;
        logic en_term;
    } t_lane_ctrl;

    // exp(-n) for integer n, Q1.16
    function automatic logic [EXP_W-1:0] exp_int(input logic [3:0] idx);
        logic [EXP_W-1:0] v;
        case (idx)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // exp(-h/16), Q1.16
    function automatic logic [EXP_W-1:0] exp_hi(input logic [3:0] idx);
        logic [EXP_W-1:0] v;
        case (idx)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd61565;
            4'd2:    v = 17'd57835;
            4'd3:    v = 17'd54331;
            4'd4:    v = 17'd51039;
            4'd5:    v = 17'd47947;
            4'd6:    v = 17'd45042;
            4'd7:    v = 17'd42313;
            4'd8:    v = 17'd39750;
            4'd9:    v = 17'd37341;
            4'd10:   v = 17'd35079;
            4'd11:   v = 17'd32954;
            4'd12:   v = 17'd30957;
            4'd13:   v = 17'd29081;
            4'd14:   v = 17'd27319;
            default: v = 17'd25664;
        endcase
        return v;
    endfunction

    // exp(-l/256), Q1.16
    function automatic logic [EXP_W-1:0] exp_lo(input logic [3:0] idx);
        logic [EXP_W-1:0] v;
        case (idx)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd65280;
            4'd2:    v = 17'd65026;
            4'd3:    v = 17'd64772;
            4'd4:    v = 17'd64520;
            4'd5:    v = 17'd64268;
            4'd6:    v = 17'd64018;
            4'd7:    v = 17'd63768;
            4'd8:    v = 17'd63520;
            4'd9:    v = 17'd63272;
            4'd10:   v = 17'd63025;
            4'd11:   v = 17'd62780;
            4'd12:   v = 17'd62535;
            4'd13:   v = 17'd62291;
            4'd14:   v = 17'd62048;
            default: v = 17'd61806;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/gpc_lane.sv
// one gaussian bump: distance, scaling, three-step exp approximation, peak scaling
// depends on gpc_pkg; six register stages, each loaded by its own enable
module gpc_lane (
    input  logic                                 i_clk,
    input  gpc_pkg::t_lane_ctrl                  i_ctrl,
    input  logic [gpc_pkg::COORD_W-1:0]          i_px,
    input  logic [gpc_pkg::COORD_W-1:0]          i_py,
    input  logic [gpc_pkg::CENTER_W-1:0]         i_center,
    input  logic [gpc_pkg::INVW_W-1:0]           i_inv_width,
    input  logic [gpc_pkg::PEAK_W-1:0]           i_peak_gain,
    output logic [gpc_pkg::TERM_W-1:0]           o_term
);

    localparam int SQ_W = 2 * gpc_pkg::COORD_W;
    localparam int D2_W = SQ_W + 1;
    localparam int TP_W = D2_W + gpc_pkg::INVW_W;
    localparam int EW   = gpc_pkg::EXP_W;

    logic [gpc_pkg::COORD_W-1:0] w_cx, w_cy, w_dx, w_dy;
    logic [D2_W-1:0]             w_d2;
    logic [TP_W-1:0]             w_tp;
    logic [2*EW-1:0]             w_p1, w_p2, w_p3;

    logic [SQ_W-1:0] r_dx2, r_dy2;
    logic [19:0]     r_t;
    logic            r_far2, r_far3, r_far4, r_far5;
    logic [EW-1:0]   r_e1, r_e2, r_e3;
    logic [3:0]      r_l3;
    logic [7:0]      r_r3, r_r4;
    logic [gpc_pkg::TERM_W-1:0] r_term;

    // absolute differences to the center
    assign w_cx = i_center[gpc_pkg::CENTER_W-1:gpc_pkg::COORD_W];
    assign w_cy = i_center[gpc_pkg::COORD_W-1:0];
    assign w_dx = (i_px >= w_cx) ? (i_px - w_cx) : (w_cx - i_px);
    assign w_dy = (i_py >= w_cy) ? (i_py - w_cy) : (w_cy - i_py);

    // stage 1: squares
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_sq) begin
            r_dx2 <= w_dx * w_dx;
            r_dy2 <= w_dy * w_dy;
        end
    end

    // stage 2: squared distance times reciprocal width
    assign w_d2 = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign w_tp = w_d2 * i_inv_width;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_scale) begin
            r_far2 <= |w_tp[TP_W-1:32];
            r_t    <= w_tp[31:12];
        end
    end

    // stage 3: integer part times high fraction
    assign w_p1 = gpc_pkg::exp_int(r_t[19:16]) * gpc_pkg::exp_hi(r_t[15:12]);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_exp_a) begin
            r_e1   <= w_p1[EW+15:16];
            r_l3   <= r_t[11:8];
            r_r3   <= r_t[7:0];
            r_far3 <= r_far2;
        end
    end

    // stage 4: low fraction
    assign w_p2 = r_e1 * gpc_pkg::exp_lo(r_l3);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_exp_b) begin
            r_e2   <= w_p2[EW+15:16];
            r_r4   <= r_r3;
            r_far4 <= r_far3;
        end
    end

    // stage 5: linear factor for the residue
    assign w_p3 = r_e2 * (gpc_pkg::ONE_Q16 - {{(EW-8){1'b0}}, r_r4});

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_exp_c) begin
            r_e3   <= w_p3[EW+15:16];
            r_far5 <= r_far4;
        end
    end

    // stage 6: scale by peak, far points add nothing
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_term) begin
            r_term <= r_far5 ? '0 : (i_peak_gain * r_e3);
        end
    end

    assign o_term = r_term;

endmodule

FILE: hdl/gaussian_potential_cost_core.sv
// Gaussian potential cost core: cost = 1 + sum of peak*exp(-d^2*inv_width) over the centers,
// rounded to unsigned Q8.8 and saturated. Fully pipelined: one point is taken every cycle
// while the pipeline is not held. There are eight register stages, and the input transfer
// itself loads the first: 6 stages per center lane, a pairwise add stage and the output
// register. A stalled output holds the pipeline, but bubbles inside are squeezed out, so
// input keeps flowing while any stage is empty.
// Configuration writes take effect at once and are meant for an idle core.
// depends on gpc_pkg and gpc_lane
module gaussian_potential_cost_core #(
    parameter int NUM_CENTERS = gpc_pkg::NUM_CENTERS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input stream
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [23:0]                  i_s_tdata,  // x_coord[11:0], y_coord[23:12]
    // output stream
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [15:0]                  o_m_tdata,  // cost_value[15:0]
    output logic                         o_m_tuser,  // clipped[0]
    // configuration write port
    input  logic                         i_cfg_we,
    input  logic [gpc_pkg::ADDR_W-1:0]   i_cfg_addr,
    input  logic [gpc_pkg::CFG_W-1:0]    i_cfg_wdata
);

    localparam int NSTAGE    = 8;
    localparam int NUM_PAIRS = (NUM_CENTERS + 1) / 2;
    localparam int PAIR_W    = gpc_pkg::TERM_W + 1;
    localparam int SUM_W     = 34;
    localparam logic [SUM_W-1:0] ONE_Q24  = SUM_W'(1) << 24;
    localparam logic [SUM_W-1:0] HALF_LSB = SUM_W'(1) << 15;

    logic [gpc_pkg::CENTER_W-1:0] r_center [gpc_pkg::MAX_CENTERS];
    logic [gpc_pkg::PEAK_W-1:0]   r_peak;
    logic [gpc_pkg::INVW_W-1:0]   r_invw;

    logic [NSTAGE-1:0]            r_valid;
    logic [NSTAGE-1:0]            w_en;
    gpc_pkg::t_lane_ctrl          w_lane_ctrl;

    logic [gpc_pkg::TERM_W-1:0]   w_term [2*NUM_PAIRS];
    logic [PAIR_W-1:0]            n_pair [NUM_PAIRS];
    logic [PAIR_W-1:0]            r_pair [NUM_PAIRS];
    logic [SUM_W-1:0]             n_total, n_round;
    logic [gpc_pkg::COST_W-1:0]   r_cost;
    logic                         r_clip;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < gpc_pkg::MAX_CENTERS; k++) begin
                r_center[k] <= gpc_pkg::CENTER_RST[k];
            end
            r_peak <= gpc_pkg::PEAK_RST;
            r_invw <= gpc_pkg::INVW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr) inside
                [gpc_pkg::CFG_CENTER_A:gpc_pkg::CFG_CENTER_F]: begin
                    r_center[i_cfg_addr] <= i_cfg_wdata;
                end
                gpc_pkg::CFG_PEAK_GAIN: begin
                    r_peak <= i_cfg_wdata[gpc_pkg::PEAK_W-1:0];
                end
                gpc_pkg::CFG_INV_WIDTH: begin
                    r_invw <= i_cfg_wdata[gpc_pkg::INVW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // stage enables: a stage loads when it is empty or its content moves on
    always_comb begin
        w_en[NSTAGE-1] = !r_valid[NSTAGE-1] || i_m_tready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    assign o_s_tready = w_en[0];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    assign w_lane_ctrl.en_sq    = w_en[0];
    assign w_lane_ctrl.en_scale = w_en[1];
    assign w_lane_ctrl.en_exp_a = w_en[2];
    assign w_lane_ctrl.en_exp_b = w_en[3];
    assign w_lane_ctrl.en_exp_c = w_en[4];
    assign w_lane_ctrl.en_term  = w_en[5];

    // one lane per center
    for (genvar g = 0; g < NUM_CENTERS; g++) begin : g_lane
        gpc_lane u_lane (
            .i_clk       (i_clk),
            .i_ctrl      (w_lane_ctrl),
            .i_px        (i_s_tdata[11:0]),
            .i_py        (i_s_tdata[23:12]),
            .i_center    (r_center[g]),
            .i_inv_width (r_invw),
            .i_peak_gain (r_peak),
            .o_term      (w_term[g])
        );
    end

    // odd center count leaves one empty slot
    for (genvar g = NUM_CENTERS; g < 2 * NUM_PAIRS; g++) begin : g_pad
        assign w_term[g] = '0;
    end

    // stage 7: pairwise sums
    always_comb begin
        for (int j = 0; j < NUM_PAIRS; j++) begin
            n_pair[j] = {1'b0, w_term[2*j]} + {1'b0, w_term[2*j+1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            for (int j = 0; j < NUM_PAIRS; j++) begin
                r_pair[j] <= n_pair[j];
            end
        end
    end

    // stage 8: total, round half up, saturate
    always_comb begin
        n_total = ONE_Q24;
        for (int j = 0; j < NUM_PAIRS; j++) begin
            n_total = n_total + SUM_W'(r_pair[j]);
        end
        n_round = n_total + HALF_LSB;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            if (|n_round[SUM_W-1:32]) begin
                r_cost <= '1;
                r_clip <= 1'b1;
            end else begin
                r_cost <= n_round[31:16];
                r_clip <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_valid[NSTAGE-1];
    assign o_m_tdata  = r_cost;
    assign o_m_tuser  = r_clip;

endmodule

FILE: hdl/gpc_checker.sv
// port-level checks for the gaussian cost core, attached by bind
// depends on gaussian_potential_cost_core
module gpc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_s_tready,
    input logic                         o_m_tvalid,
    input logic                         i_m_tready,
    input logic [15:0]                  o_m_tdata,
    input logic                         o_m_tuser
);

    // nothing leaves right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    // an undelivered result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // an empty output register never blocks input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked with empty output");

    // a draining output never blocks input
    a_drain_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tready |-> o_s_tready)
        else $error("input blocked while output drains");

    // the clip flag comes only with the saturated cost
    a_clip_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == 16'hFFFF)
        else $error("clip flag without saturated cost");

endmodule

bind gaussian_potential_cost_core gpc_checker u_gpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser)
);
